>>> rtl/core/dtce_pkg.sv
// Shared types, constants and the sequencer microcode for the DRAM command expander.
package dtce_pkg;

  localparam int MAX_CHUNKS = 16;
  localparam int MAX_BANKS  = 16;

  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 40;
  localparam int DW_W     = 16;
  localparam int CW_W     = 13;
  localparam int NB_W     = 5;
  localparam int SEQ_W    = 32;
  localparam int TYPE_W   = 3;
  localparam int APB_DW   = 32;
  localparam int PADDR_W  = 4;
  localparam int REF_SHIFT = 5;  // refresh stride of 32 address units

  // Running chunk end fits with one chunk width of headroom above the data width.
  localparam int REACH_W     = DW_W + 1;
  localparam int CHUNK_IDX_W = $clog2(MAX_CHUNKS + 1);
  localparam int CCMP_W      = CHUNK_IDX_W + 1;
  localparam int BANK_IDX_W  = $clog2(MAX_BANKS + 1);
  localparam int BCMP_W      = ((BANK_IDX_W > NB_W) ? BANK_IDX_W : NB_W) + 1;

  localparam logic [CW_W-1:0] CHUNK_WIDTH_RST = CW_W'(64);
  localparam logic [NB_W-1:0] NUM_BANKS_RST   = NB_W'(8);

  typedef enum logic [CMD_W-1:0] {
    RC_READ    = 2'd0,
    RC_WRITE   = 2'd1,
    RC_REFRESH = 2'd2
  } req_cmd_t;

  typedef enum logic [TYPE_W-1:0] {
    CT_ACT    = 3'd0,
    CT_READ   = 3'd1,
    CT_READA  = 3'd2,
    CT_WRITE  = 3'd3,
    CT_WRITEA = 3'd4,
    CT_PRE    = 3'd5,
    CT_REF    = 3'd6
  } cmd_type_t;

  typedef enum logic [1:0] {
    RI_CHUNK_WIDTH    = 2'd0,
    RI_USE_READ_AUTO  = 2'd1,
    RI_USE_WRITE_AUTO = 2'd2,
    RI_NUM_BANKS      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CW_W-1:0] chunk_width;
    logic            use_read_auto;
    logic            use_write_auto;
    logic [NB_W-1:0] num_banks;
  } cfg_t;

  // Command kind that a microcode step emits.
  typedef enum logic [2:0] {
    K_NONE,
    K_ACT,
    K_ACCESS,
    K_PRE,
    K_REF
  } kind_t;

  // How a step picks its successor.
  typedef enum logic [1:0] {
    SQ_GOTO,
    SQ_DISPATCH,
    SQ_CHUNK,
    SQ_BANK
  } seq_op_t;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE   = 3'd0;
  localparam step_t ST_ACT    = 3'd1;
  localparam step_t ST_ACCESS = 3'd2;
  localparam step_t ST_PRE    = 3'd3;
  localparam step_t ST_REF    = 3'd4;

  typedef struct packed {
    logic    ready;
    kind_t   kind;
    seq_op_t seq;
    step_t   tgt_a;
    step_t   tgt_b;
  } ucw_t;

  typedef struct packed {
    logic  load;
    logic  emit;
    kind_t kind;
    logic  chunk_end;
    logic  last;
  } seq_ctrl_t;

  typedef struct packed {
    logic mem_ok;
    logic ref_ok;
    logic auto_pre;
    logic more_chunks;
    logic more_banks;
    logic out_free;
  } dp_status_t;

  // Microprogram. The access step falls through to the precharge step unless it
  // closes the chunk itself with auto precharge.
  function automatic ucw_t ucode_rom(input step_t step);
    ucw_t w;
    unique case (step)
      ST_IDLE:   w = '{ready: 1'b1, kind: K_NONE,   seq: SQ_DISPATCH, tgt_a: ST_ACT, tgt_b: ST_REF};
      ST_ACT:    w = '{ready: 1'b0, kind: K_ACT,    seq: SQ_GOTO,     tgt_a: ST_ACCESS,
                       tgt_b: ST_IDLE};
      ST_ACCESS: w = '{ready: 1'b0, kind: K_ACCESS, seq: SQ_CHUNK,    tgt_a: ST_ACT, tgt_b: ST_IDLE};
      ST_PRE:    w = '{ready: 1'b0, kind: K_PRE,    seq: SQ_CHUNK,    tgt_a: ST_ACT, tgt_b: ST_IDLE};
      ST_REF:    w = '{ready: 1'b0, kind: K_REF,    seq: SQ_BANK,     tgt_a: ST_REF, tgt_b: ST_IDLE};
      default:   w = '{ready: 1'b0, kind: K_NONE,   seq: SQ_GOTO,     tgt_a: ST_IDLE,
                       tgt_b: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/dtce_req_if.sv
// Request channel carrying one transaction: command, start address and size.
interface dtce_req_if;
  logic                        valid;
  logic                        ready;
  logic [dtce_pkg::CMD_W-1:0]  command;
  logic [dtce_pkg::ADDR_W-1:0] address;
  logic [dtce_pkg::DW_W-1:0]   data_width;

  modport source (output valid, command, address, data_width, input ready);
  modport sink   (input valid, command, address, data_width, output ready);
endinterface

>>> rtl/core/dtce_cmd_if.sv
// Command channel carrying one DRAM bank command per transfer.
interface dtce_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [dtce_pkg::TYPE_W-1:0] cmd_type;
  logic [dtce_pkg::ADDR_W-1:0] cmd_address;
  logic [dtce_pkg::SEQ_W-1:0]  seq_num;
  logic                        last;

  modport source (output valid, cmd_type, cmd_address, seq_num, last, input ready);
  modport sink   (input valid, cmd_type, cmd_address, seq_num, last, output ready);
endinterface

>>> rtl/core/dtce_regs.sv
// APB configuration registers: chunk width, auto-precharge enables, bank count.
module dtce_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dtce_pkg::PADDR_W-1:0] paddr,
  input  logic [dtce_pkg::APB_DW-1:0]  pwdata,
  output logic [dtce_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output dtce_pkg::cfg_t               cfg
);

  dtce_pkg::cfg_t     cfg_next;
  dtce_pkg::reg_idx_t idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = dtce_pkg::reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;

  always_comb begin
    cfg_next = cfg;
    if (wr) begin
      unique case (idx)
        dtce_pkg::RI_CHUNK_WIDTH:    cfg_next.chunk_width    = pwdata[dtce_pkg::CW_W-1:0];
        dtce_pkg::RI_USE_READ_AUTO:  cfg_next.use_read_auto  = pwdata[0];
        dtce_pkg::RI_USE_WRITE_AUTO: cfg_next.use_write_auto = pwdata[0];
        dtce_pkg::RI_NUM_BANKS:      cfg_next.num_banks      = pwdata[dtce_pkg::NB_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dtce_pkg::RI_CHUNK_WIDTH:    prdata = dtce_pkg::APB_DW'(cfg.chunk_width);
      dtce_pkg::RI_USE_READ_AUTO:  prdata = dtce_pkg::APB_DW'(cfg.use_read_auto);
      dtce_pkg::RI_USE_WRITE_AUTO: prdata = dtce_pkg::APB_DW'(cfg.use_write_auto);
      dtce_pkg::RI_NUM_BANKS:      prdata = dtce_pkg::APB_DW'(cfg.num_banks);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chunk_width    <= dtce_pkg::CHUNK_WIDTH_RST;
      cfg.use_read_auto  <= 1'b0;
      cfg.use_write_auto <= 1'b0;
      cfg.num_banks      <= dtce_pkg::NUM_BANKS_RST;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

>>> rtl/core/dtce_useq.sv
// Microcode sequencer: step counter, control ROM and conditional next-step logic.
module dtce_useq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   txn_valid,
  output logic                   txn_ready,
  input  dtce_pkg::dp_status_t   status,
  output dtce_pkg::seq_ctrl_t    ctrl
);

  dtce_pkg::step_t step;
  dtce_pkg::step_t step_next;
  dtce_pkg::ucw_t  ucw;

  always_comb begin
    ucw       = dtce_pkg::ucode_rom(step);
    txn_ready = ucw.ready;

    ctrl.kind      = ucw.kind;
    ctrl.load      = txn_valid && ucw.ready;
    ctrl.emit      = (ucw.kind != dtce_pkg::K_NONE) && status.out_free;
    ctrl.chunk_end = (ucw.kind == dtce_pkg::K_PRE) ||
                     ((ucw.kind == dtce_pkg::K_ACCESS) && status.auto_pre);
    ctrl.last      = (ucw.kind == dtce_pkg::K_REF) ? !status.more_banks
                                                   : (ctrl.chunk_end && !status.more_chunks);

    // Emitting steps only move on once their command has gone into the output register.
    step_next = step;
    unique case (ucw.seq)
      dtce_pkg::SQ_GOTO: begin
        if (ctrl.emit) step_next = ucw.tgt_a;
      end
      dtce_pkg::SQ_DISPATCH: begin
        if (ctrl.load) begin
          priority if (status.mem_ok) step_next = ucw.tgt_a;
          else if (status.ref_ok)     step_next = ucw.tgt_b;
          else                        step_next = step;
        end
      end
      dtce_pkg::SQ_CHUNK: begin
        if (ctrl.emit) begin
          if (!ctrl.chunk_end)         step_next = step + dtce_pkg::STEP_W'(1);
          else if (status.more_chunks) step_next = ucw.tgt_a;
          else                         step_next = ucw.tgt_b;
        end
      end
      dtce_pkg::SQ_BANK: begin
        if (ctrl.emit) step_next = status.more_banks ? ucw.tgt_a : ucw.tgt_b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= dtce_pkg::ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

`ifndef SYNTHESIS
  a_last_returns_idle: assert property (@(posedge clk)
    (!rst && ctrl.emit && ctrl.last) |=> (step == dtce_pkg::ST_IDLE))
    else $error("sequencer did not return to idle after the final command");

  a_mid_stays_busy: assert property (@(posedge clk) disable iff (rst)
    (!rst && ctrl.emit && !ctrl.last) |=> (step != dtce_pkg::ST_IDLE))
    else $error("sequencer went idle before the final command");

  a_step_in_program: assert property (@(posedge clk) disable iff (rst)
    step <= dtce_pkg::ST_REF)
    else $error("step counter left the microprogram");
`endif

endmodule

>>> rtl/core/dtce_dpath.sv
// Datapath: chunk address and extent tracking, bank counter, sequence counter, output register.
module dtce_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  dtce_pkg::cfg_t               cfg,
  input  dtce_pkg::seq_ctrl_t          ctrl,
  input  logic [dtce_pkg::CMD_W-1:0]   command,
  input  logic [dtce_pkg::ADDR_W-1:0]  address,
  input  logic [dtce_pkg::DW_W-1:0]    data_width,
  output dtce_pkg::dp_status_t         status,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [dtce_pkg::TYPE_W-1:0]  cmd_type,
  output logic [dtce_pkg::ADDR_W-1:0]  cmd_address,
  output logic [dtce_pkg::SEQ_W-1:0]   seq_num,
  output logic                         last
);

  logic                             is_read;
  logic [dtce_pkg::ADDR_W-1:0]      chunk_addr;
  logic [dtce_pkg::REACH_W-1:0]     reach;       // end of the current chunk
  logic [dtce_pkg::DW_W-1:0]        dw_q;
  logic [dtce_pkg::CHUNK_IDX_W-1:0] chunk_idx;
  logic [dtce_pkg::BANK_IDX_W-1:0]  bank_idx;
  logic [dtce_pkg::SEQ_W-1:0]       next_seq;

  logic [dtce_pkg::REACH_W:0]       reach_sum;
  logic [dtce_pkg::CCMP_W-1:0]      chunk_inc;
  logic [dtce_pkg::BCMP_W-1:0]      bank_inc;
  logic [dtce_pkg::BCMP_W-1:0]      nb_ext;
  logic [dtce_pkg::BCMP_W-1:0]      nb_sat;
  dtce_pkg::cmd_type_t              access_type;
  dtce_pkg::cmd_type_t              emit_type;
  logic [dtce_pkg::ADDR_W-1:0]      emit_addr;

  always_comb begin
    reach_sum = (dtce_pkg::REACH_W+1)'(reach) + (dtce_pkg::REACH_W+1)'(cfg.chunk_width);
    chunk_inc = dtce_pkg::CCMP_W'(chunk_idx) + dtce_pkg::CCMP_W'(1);
    bank_inc  = dtce_pkg::BCMP_W'(bank_idx) + dtce_pkg::BCMP_W'(1);
    nb_ext    = dtce_pkg::BCMP_W'(cfg.num_banks);
    nb_sat    = (nb_ext > dtce_pkg::BCMP_W'(dtce_pkg::MAX_BANKS))
                ? dtce_pkg::BCMP_W'(dtce_pkg::MAX_BANKS) : nb_ext;

    status.mem_ok      = ((command == dtce_pkg::RC_READ) || (command == dtce_pkg::RC_WRITE)) &&
                         (cfg.chunk_width != '0) &&
                         (dtce_pkg::DW_W'(cfg.chunk_width) <= data_width);
    status.ref_ok      = (command == dtce_pkg::RC_REFRESH) && (cfg.num_banks != '0);
    status.auto_pre    = is_read ? cfg.use_read_auto : cfg.use_write_auto;
    status.more_chunks = (reach_sum <= (dtce_pkg::REACH_W+1)'(dw_q)) &&
                         (chunk_inc < dtce_pkg::CCMP_W'(dtce_pkg::MAX_CHUNKS));
    status.more_banks  = bank_inc < nb_sat;
    status.out_free    = !out_valid || out_ready;

    if (is_read) access_type = status.auto_pre ? dtce_pkg::CT_READA : dtce_pkg::CT_READ;
    else         access_type = status.auto_pre ? dtce_pkg::CT_WRITEA : dtce_pkg::CT_WRITE;

    emit_addr = chunk_addr;
    unique case (ctrl.kind)
      dtce_pkg::K_ACT:    emit_type = dtce_pkg::CT_ACT;
      dtce_pkg::K_ACCESS: emit_type = access_type;
      dtce_pkg::K_PRE:    emit_type = dtce_pkg::CT_PRE;
      dtce_pkg::K_REF: begin
        emit_type = dtce_pkg::CT_REF;
        emit_addr = dtce_pkg::ADDR_W'(bank_idx) << dtce_pkg::REF_SHIFT;
      end
      default:            emit_type = dtce_pkg::CT_ACT;
    endcase
  end

  // Working registers for the transaction in flight.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      is_read    <= (command == dtce_pkg::RC_READ);
      chunk_addr <= address;
      reach      <= dtce_pkg::REACH_W'(cfg.chunk_width);
      dw_q       <= data_width;
      chunk_idx  <= '0;
      bank_idx   <= '0;
    end else if (ctrl.emit) begin
      if (ctrl.chunk_end) begin
        chunk_addr <= chunk_addr + dtce_pkg::ADDR_W'(cfg.chunk_width);
        reach      <= reach_sum[dtce_pkg::REACH_W-1:0];
        chunk_idx  <= chunk_inc[dtce_pkg::CHUNK_IDX_W-1:0];
      end
      if (ctrl.kind == dtce_pkg::K_REF) begin
        bank_idx <= bank_inc[dtce_pkg::BANK_IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_seq  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.emit) begin
        next_seq  <= next_seq + dtce_pkg::SEQ_W'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      cmd_type    <= emit_type;
      cmd_address <= emit_addr;
      seq_num     <= next_seq;
      last        <= ctrl.last;
    end
  end

`ifndef SYNTHESIS
  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    (!rst && ctrl.emit) |=> (next_seq == $past(next_seq) + dtce_pkg::SEQ_W'(1)))
    else $error("sequence counter did not advance by one per command");

  a_chunk_cap: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit && (ctrl.kind == dtce_pkg::K_ACT)) |->
      (dtce_pkg::CCMP_W'(chunk_idx) < dtce_pkg::CCMP_W'(dtce_pkg::MAX_CHUNKS)))
    else $error("chunk index passed the chunk limit");
`endif

endmodule

>>> rtl/core/dram_transaction_to_command_expander.sv
// Top level of the DRAM transaction to bank command expander.
// Each accepted transaction becomes a run of bank commands, one per cycle while
// the command channel is not stalled: a read or write yields ACT, READ/WRITE,
// PRE per chunk (ACT, READA/WRITEA with auto precharge), a refresh yields one
// REF per bank at 32 times the bank number. Every command carries the next value
// of a 32-bit sequence counter, and the final command of a transaction has last
// set. The microcode sequencer decodes each transaction in its idle step, then
// emits at most one command per cycle into a single output register, and
// back-pressure on the command channel stalls it; a transaction that yields no
// command leaves it idle. Configuration registers sit on the APB port at byte
// addresses 0, 4, 8 and 12 and must be written only while no transaction is in
// progress; the block itself does not enforce this.
module dram_transaction_to_command_expander (
  input  logic                         clk,
  input  logic                         rst,
  dtce_req_if.sink                     txn,
  dtce_cmd_if.source                   bank_cmd,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dtce_pkg::PADDR_W-1:0] paddr,
  input  logic [dtce_pkg::APB_DW-1:0]  pwdata,
  output logic [dtce_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  dtce_pkg::cfg_t       cfg;
  dtce_pkg::seq_ctrl_t  ctrl;
  dtce_pkg::dp_status_t status;

  dtce_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dtce_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .txn_valid (txn.valid),
    .txn_ready (txn.ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  dtce_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .ctrl        (ctrl),
    .command     (txn.command),
    .address     (txn.address),
    .data_width  (txn.data_width),
    .status      (status),
    .out_ready   (bank_cmd.ready),
    .out_valid   (bank_cmd.valid),
    .cmd_type    (bank_cmd.cmd_type),
    .cmd_address (bank_cmd.cmd_address),
    .seq_num     (bank_cmd.seq_num),
    .last        (bank_cmd.last)
  );

endmodule
